/* sv/single_wire_sensor_frame_decoder_defines.svh */
// Assertion macros for the single-wire sensor frame decoder.
// Each macro expects clk and arst_n in the scope of its use.
`ifndef SINGLE_WIRE_SENSOR_FRAME_DECODER_DEFINES_SVH
`define SINGLE_WIRE_SENSOR_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SWSFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SWSFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/swsfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package swsfd_pkg;

	localparam int OPCODE_W = 2;
	localparam int TIMER_W  = 16;
	localparam int ERR_W    = 3;
	localparam int WORD_W   = 16;
	localparam int BITS_W   = 40;
	localparam int COUNT_W  = 7;

	localparam logic [COUNT_W-1:0] FRAME_INTERVALS = 7'd82;

	localparam logic [TIMER_W-1:0] PRE_MIN  = 16'd60;
	localparam logic [TIMER_W-1:0] PRE_MAX  = 16'd100;
	localparam logic [TIMER_W-1:0] LOW_MIN  = 16'd35;
	localparam logic [TIMER_W-1:0] LOW_MAX  = 16'd70;
	localparam logic [TIMER_W-1:0] ZERO_MIN = 16'd10;
	localparam logic [TIMER_W-1:0] ZERO_MAX = 16'd45;
	localparam logic [TIMER_W-1:0] ONE_MIN  = 16'd55;
	localparam logic [TIMER_W-1:0] ONE_MAX  = 16'd95;

	typedef enum logic [OPCODE_W-1:0] {
		OP_START = 2'd0,
		OP_EDGE  = 2'd1,
		OP_END   = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 3'd0,
		ERR_TYPE     = 3'd1,
		ERR_PREAMBLE = 3'd2,
		ERR_LOW      = 3'd3,
		ERR_HIGH     = 3'd4,
		ERR_SHORT    = 3'd5,
		ERR_SUM      = 3'd6
	} err_t;

endpackage
`default_nettype wire

/* sv/swsfd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface swsfd_item_if;
	logic                              valid;
	logic                              ready;
	logic [swsfd_pkg::OPCODE_W-1:0]    opcode;
	logic [swsfd_pkg::TIMER_W-1:0]     timer_value;

	modport source (output valid, opcode, timer_value, input ready);
	modport sink   (input valid, opcode, timer_value, output ready);
endinterface

interface swsfd_result_if;
	logic                              valid;
	logic                              ready;
	logic                              frame_ok;
	logic [swsfd_pkg::ERR_W-1:0]       error_code;
	logic [swsfd_pkg::WORD_W-1:0]      humidity_tenths;
	logic [swsfd_pkg::WORD_W-1:0]      temperature_tenths;

	modport source (output valid, frame_ok, error_code, humidity_tenths,
		temperature_tenths, input ready);
	modport sink   (input valid, frame_ok, error_code, humidity_tenths,
		temperature_tenths, output ready);
endinterface
`default_nettype wire

/* sv/single_wire_sensor_frame_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Role   | Payload                                          | Moves
// item     | sink   | opcode, timer_value                              | one event per transfer
// result   | source | frame_ok, error_code, humidity_tenths,           | one result per end item
//          |        | temperature_tenths                               |
// cfg_wr_* | write  | sensor_kind_supported                            | write on cfg_wr_en
//
// Flow: one item per cycle unless an end item stalls; each item is registered in the input
//   register, and an end item's result is then registered in the result register.
// Reset: arst_n clears frame state, both valid flags and sets sensor_kind_supported to 1.
// Stalls: only an end item waiting in the input register while the result register is still
//   full and not taken holds back the input; start and edge items never stall.
`include "single_wire_sensor_frame_decoder_defines.svh"

module single_wire_sensor_frame_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	swsfd_item_if.sink       item,
	swsfd_result_if.source   result
);

	// Configuration register
	logic kind_ok_q;

	// Input register (stage 1)
	logic                              valid_s1;
	swsfd_pkg::opcode_t                opcode_s1;
	logic [swsfd_pkg::TIMER_W-1:0]     timer_s1;

	// Frame state
	logic [swsfd_pkg::COUNT_W-1:0]     edge_count_q;
	logic [swsfd_pkg::TIMER_W-1:0]     last_stamp_q;
	logic                              low_ok_q;
	logic [swsfd_pkg::BITS_W-1:0]      frame_bits_q;
	swsfd_pkg::err_t                   first_error_q;

	// Next frame state
	logic [swsfd_pkg::COUNT_W-1:0]     edge_count_d;
	logic [swsfd_pkg::TIMER_W-1:0]     last_stamp_d;
	logic                              low_ok_d;
	logic [swsfd_pkg::BITS_W-1:0]      frame_bits_d;
	swsfd_pkg::err_t                   first_error_d;

	// Result register
	logic                              res_valid_q;
	logic                              res_ok_q;
	swsfd_pkg::err_t                   res_err_q;
	logic [swsfd_pkg::WORD_W-1:0]      res_hum_q;
	logic [swsfd_pkg::WORD_W-1:0]      res_temp_q;

	logic                              s1_stall;
	logic                              s1_adv;
	logic                              in_xfer;
	logic                              emit;
	logic [swsfd_pkg::TIMER_W-1:0]     gap;
	logic                              gap_pre;
	logic                              gap_low;
	logic                              gap_zero;
	logic                              gap_one;
	logic [7:0]                        b0, b1, b2, b3, b4;
	logic [9:0]                        byte_sum;
	swsfd_pkg::err_t                   err_now;

	// Handshake: stall only an end item that has nowhere to put its result
	assign s1_stall = valid_s1 && (opcode_s1 == swsfd_pkg::OP_END) &&
		res_valid_q && !result.ready;
	assign s1_adv   = valid_s1 && !s1_stall;
	assign item.ready = !s1_stall;
	assign in_xfer  = item.valid && item.ready;
	assign emit     = s1_adv && (opcode_s1 == swsfd_pkg::OP_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_ok_q <= 1'b1;
		end else if (cfg_wr_en) begin
			kind_ok_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!s1_stall) begin
			valid_s1 <= item.valid;
		end
	end

	// Input payload: hold while stalled, capture on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1 <= swsfd_pkg::opcode_t'(item.opcode);
			timer_s1  <= item.timer_value;
		end
	end

	// Interval since the last stamp, modulo the timer width
	assign gap      = timer_s1 - last_stamp_q;
	assign gap_pre  = (gap >= swsfd_pkg::PRE_MIN)  && (gap <= swsfd_pkg::PRE_MAX);
	assign gap_low  = (gap >= swsfd_pkg::LOW_MIN)  && (gap <= swsfd_pkg::LOW_MAX);
	assign gap_zero = (gap >= swsfd_pkg::ZERO_MIN) && (gap <= swsfd_pkg::ZERO_MAX);
	assign gap_one  = (gap >= swsfd_pkg::ONE_MIN)  && (gap <= swsfd_pkg::ONE_MAX);

	// Next frame state for the item in stage 1
	always_comb begin
		edge_count_d  = edge_count_q;
		last_stamp_d  = last_stamp_q;
		low_ok_d      = low_ok_q;
		frame_bits_d  = frame_bits_q;
		first_error_d = first_error_q;
		case (opcode_s1)
			swsfd_pkg::OP_START: begin
				edge_count_d  = '0;
				last_stamp_d  = '0;
				low_ok_d      = 1'b0;
				frame_bits_d  = '0;
				first_error_d = swsfd_pkg::ERR_NONE;
			end
			swsfd_pkg::OP_EDGE: begin
				// Drop edges once the frame holds all its intervals
				if (edge_count_q < swsfd_pkg::FRAME_INTERVALS) begin
					last_stamp_d = timer_s1;
					edge_count_d = edge_count_q + 7'd1;
					if (edge_count_q < 7'd2) begin
						// Preamble interval
						if (!gap_pre && first_error_q == swsfd_pkg::ERR_NONE) begin
							first_error_d = swsfd_pkg::ERR_PREAMBLE;
						end
					end else if (!edge_count_q[0]) begin
						// Low phase of a bit
						low_ok_d = gap_low;
						if (!gap_low && first_error_q == swsfd_pkg::ERR_NONE) begin
							first_error_d = swsfd_pkg::ERR_LOW;
						end
					end else if (low_ok_q) begin
						// High phase: width selects the bit value
						if (gap_zero) begin
							frame_bits_d = {frame_bits_q[swsfd_pkg::BITS_W-2:0], 1'b0};
						end else if (gap_one) begin
							frame_bits_d = {frame_bits_q[swsfd_pkg::BITS_W-2:0], 1'b1};
						end else if (first_error_q == swsfd_pkg::ERR_NONE) begin
							first_error_d = swsfd_pkg::ERR_HIGH;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q  <= '0;
			last_stamp_q  <= '0;
			low_ok_q      <= 1'b0;
			frame_bits_q  <= '0;
			first_error_q <= swsfd_pkg::ERR_NONE;
		end else if (s1_adv) begin
			edge_count_q  <= edge_count_d;
			last_stamp_q  <= last_stamp_d;
			low_ok_q      <= low_ok_d;
			frame_bits_q  <= frame_bits_d;
			first_error_q <= first_error_d;
		end
	end

	// Frame bytes, first received byte in the top bits
	assign b0 = frame_bits_q[39:32];
	assign b1 = frame_bits_q[31:24];
	assign b2 = frame_bits_q[23:16];
	assign b3 = frame_bits_q[15:8];
	assign b4 = frame_bits_q[7:0];
	assign byte_sum = {2'b00, b0} + {2'b00, b1} + {2'b00, b2} + {2'b00, b3};

	// Error priority: sensor type, first interval error, short frame, checksum
	always_comb begin
		if (!kind_ok_q) begin
			err_now = swsfd_pkg::ERR_TYPE;
		end else if (first_error_q != swsfd_pkg::ERR_NONE) begin
			err_now = first_error_q;
		end else if (edge_count_q < swsfd_pkg::FRAME_INTERVALS) begin
			err_now = swsfd_pkg::ERR_SHORT;
		end else if (byte_sum[7:0] != b4) begin
			err_now = swsfd_pkg::ERR_SUM;
		end else begin
			err_now = swsfd_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload: words only on a good frame, zero otherwise
	always_ff @(posedge clk) begin
		if (emit) begin
			res_err_q <= err_now;
			if (err_now == swsfd_pkg::ERR_NONE) begin
				res_ok_q   <= 1'b1;
				res_hum_q  <= {b0, b1};
				res_temp_q <= {b2, b3};
			end else begin
				res_ok_q   <= 1'b0;
				res_hum_q  <= '0;
				res_temp_q <= '0;
			end
		end
	end

	assign result.valid              = res_valid_q;
	assign result.frame_ok           = res_ok_q;
	assign result.error_code         = res_err_q;
	assign result.humidity_tenths    = res_hum_q;
	assign result.temperature_tenths = res_temp_q;

	`SWSFD_ASSERT_NOW(a_count_bound, 1'b1, edge_count_q <= swsfd_pkg::FRAME_INTERVALS, "edge count past frame length")
	`SWSFD_ASSERT_NOW(a_ok_no_err, result.valid && result.frame_ok, result.error_code == swsfd_pkg::ERR_NONE, "good frame carries an error")
	`SWSFD_ASSERT_NOW(a_fail_has_err, result.valid && !result.frame_ok, result.error_code != swsfd_pkg::ERR_NONE, "failed frame without error code")
	`SWSFD_ASSERT_NEXT(a_start_clears, s1_adv && opcode_s1 == swsfd_pkg::OP_START, edge_count_q == '0 && first_error_q == swsfd_pkg::ERR_NONE, "start did not clear frame")
	`SWSFD_ASSERT_NEXT(a_err_sticky, first_error_q != swsfd_pkg::ERR_NONE && !(s1_adv && opcode_s1 == swsfd_pkg::OP_START), first_error_q == $past(first_error_q), "first error overwritten")

endmodule
`default_nettype wire

/* tb/swsfd_checker.sv */
`timescale 1ns / 1ps
module swsfd_checker
	import swsfd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  logic     cfg_wr_data,
	swsfd_item_if    item,
	swsfd_result_if  result,
	input  logic     end_of_run,
	output int       fail_count,
	output int       pending,
	output int       checked,
	output int       good_frames
);

	typedef struct packed {
		logic                frame_ok;
		err_t                error_code;
		logic [WORD_W-1:0]   humidity;
		logic [WORD_W-1:0]   temperature;
	} frame_result_t;

	frame_result_t        expected_frames[$];

	// Shadow of the decoder frame state and its configuration register.
	logic                 kind_ok = 1'b1;
	logic [COUNT_W-1:0]   edges_taken = '0;
	logic [TIMER_W-1:0]   prev_stamp = '0;
	logic                 low_phase_ok = 1'b0;
	logic [BITS_W-1:0]    shift_bits = '0;
	err_t                 first_err = ERR_NONE;

	int                   mismatches = 0;
	int                   n_checked = 0;
	int                   n_good = 0;
	bit                   leftovers_done = 1'b0;

	task automatic report_mismatch(string msg);
		if (mismatches < 50)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic in_window(logic [TIMER_W-1:0] v, logic [TIMER_W-1:0] lo,
		logic [TIMER_W-1:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

	task automatic note_error(err_t code);
		if (first_err == ERR_NONE)
			first_err = code;
	endtask

	task automatic clear_frame();
		edges_taken  = '0;
		prev_stamp   = '0;
		low_phase_ok = 1'b0;
		shift_bits   = '0;
		first_err    = ERR_NONE;
	endtask

	task automatic take_edge(logic [TIMER_W-1:0] stamp);
		logic [TIMER_W-1:0] gap;
		logic [COUNT_W-1:0] idx;
		if (edges_taken >= FRAME_INTERVALS)
			return;
		gap = stamp - prev_stamp;
		prev_stamp = stamp;
		idx = edges_taken;
		edges_taken++;
		if (idx < 2) begin
			if (!in_window(gap, PRE_MIN, PRE_MAX))
				note_error(ERR_PREAMBLE);
		end else if (idx[0] == 1'b0) begin
			low_phase_ok = in_window(gap, LOW_MIN, LOW_MAX);
			if (!low_phase_ok)
				note_error(ERR_LOW);
		end else if (low_phase_ok) begin
			if (in_window(gap, ZERO_MIN, ZERO_MAX))
				shift_bits = {shift_bits[BITS_W-2:0], 1'b0};
			else if (in_window(gap, ONE_MIN, ONE_MAX))
				shift_bits = {shift_bits[BITS_W-2:0], 1'b1};
			else
				note_error(ERR_HIGH);
		end
	endtask

	function automatic frame_result_t decode_frame();
		frame_result_t r;
		logic [7:0]    b0, b1, b2, b3, b4, sum8;
		err_t          err;
		{b0, b1, b2, b3, b4} = shift_bits;
		sum8 = b0 + b1 + b2 + b3;
		if (!kind_ok)
			err = ERR_TYPE;
		else if (first_err != ERR_NONE)
			err = first_err;
		else if (edges_taken < FRAME_INTERVALS)
			err = ERR_SHORT;
		else if (sum8 != b4)
			err = ERR_SUM;
		else
			err = ERR_NONE;
		r.frame_ok    = (err == ERR_NONE);
		r.error_code  = err;
		r.humidity    = r.frame_ok ? {b0, b1} : '0;
		r.temperature = r.frame_ok ? {b2, b3} : '0;
		return r;
	endfunction

	task automatic check_result();
		frame_result_t want;
		if (expected_frames.size() == 0) begin
			report_mismatch("result with no frame end waiting");
			return;
		end
		want = expected_frames.pop_front();
		n_checked++;
		if (result.frame_ok !== want.frame_ok)
			report_mismatch($sformatf("frame_ok %b, want %b", result.frame_ok, want.frame_ok));
		if (result.error_code !== want.error_code)
			report_mismatch($sformatf("error_code %0d, want %0d", result.error_code,
				want.error_code));
		if (result.humidity_tenths !== want.humidity)
			report_mismatch($sformatf("humidity_tenths %h, want %h", result.humidity_tenths,
				want.humidity));
		if (result.temperature_tenths !== want.temperature)
			report_mismatch($sformatf("temperature_tenths %h, want %h",
				result.temperature_tenths, want.temperature));
		if (want.frame_ok)
			n_good++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_ok = 1'b1;
			clear_frame();
			expected_frames.delete();
			fail_count  <= 0;
			pending     <= 0;
			checked     <= 0;
			good_frames <= 0;
		end else begin
			// Results first: nothing accepted at this edge can already have come out.
			if (result.valid === 1'b1 && result.ready === 1'b1)
				check_result();
			if (item.valid === 1'b1 && item.ready === 1'b1) begin
				case (opcode_t'(item.opcode))
					OP_START: clear_frame();
					OP_EDGE:  take_edge(item.timer_value);
					OP_END:   expected_frames.push_back(decode_frame());
					default: ;
				endcase
			end
			if (cfg_wr_en === 1'b1)
				kind_ok = cfg_wr_data;
			if (end_of_run === 1'b1 && !leftovers_done) begin
				leftovers_done = 1'b1;
				if (expected_frames.size() != 0)
					report_mismatch($sformatf("%0d frame results never arrived",
						expected_frames.size()));
			end
			fail_count  <= mismatches;
			pending     <= expected_frames.size();
			checked     <= n_checked;
			good_frames <= n_good;
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
	import swsfd_pkg::*;

	// Receiver hold-off used to back the block up onto its input.
	localparam int STALL_CYCLES = 200;
	// Cycles to let the pipeline drain after the last expected result.
	localparam int DRAIN_CYCLES = 6;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic end_of_run;

	int   fail_count;
	int   pending;
	int   checked;
	int   good_frames;

	int   items_sent = 0;
	int   ends_sent = 0;
	int   cfg_writes = 0;
	bit   idle_off = 1'b0;
	bit   stall_request = 1'b0;
	bit   stall_active = 1'b0;
	bit   stall_done = 1'b0;

	logic [TIMER_W-1:0] frame_gaps[$];

	swsfd_item_if   item_bus();
	swsfd_result_if result_bus();

	single_wire_sensor_frame_decoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item_bus),
		.result      (result_bus)
	);

	swsfd_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item_bus),
		.result      (result_bus),
		.end_of_run  (end_of_run),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.good_frames (good_frames)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (idle_off || r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// Interval inside a window, biased toward both limits.
	function automatic logic [TIMER_W-1:0] pick_in_window(int lo, int hi);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return TIMER_W'(lo);
		if (r == 1)
			return TIMER_W'(hi);
		return TIMER_W'($urandom_range(lo, hi));
	endfunction

	// Interval just outside a window most of the time, far outside now and then.
	function automatic logic [TIMER_W-1:0] pick_off_window(int lo, int hi);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return TIMER_W'(lo - 1);
		if (r < 7)
			return TIMER_W'(hi + 1);
		if (r == 7)
			return TIMER_W'($urandom_range(0, lo - 1));
		if (r == 8)
			return TIMER_W'($urandom_range(hi + 1, hi + 60));
		return TIMER_W'($urandom_range(hi + 1, 65535));
	endfunction

	// A high phase that is neither a zero nor a one.
	function automatic logic [TIMER_W-1:0] pick_bad_high();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return TIMER_W'(ZERO_MIN - 1);
			1: return TIMER_W'(ZERO_MAX + 1);
			2: return TIMER_W'(ONE_MIN - 1);
			3: return TIMER_W'(ONE_MAX + 1);
			4: return TIMER_W'($urandom_range(0, ZERO_MIN - 1));
			5: return TIMER_W'($urandom_range(ZERO_MAX + 1, ONE_MIN - 1));
			9: return TIMER_W'($urandom_range(201, 65535));
			default: return TIMER_W'($urandom_range(ONE_MAX + 1, 200));
		endcase
	endfunction

	// Four random data bytes and their checksum; corrupt the checksum if asked.
	function automatic logic [BITS_W-1:0] random_frame_bits(bit corrupt);
		logic [7:0] b0, b1, b2, b3, b4;
		b0 = 8'($urandom);
		b1 = 8'($urandom);
		b2 = 8'($urandom);
		b3 = 8'($urandom);
		b4 = b0 + b1 + b2 + b3;
		if (corrupt)
			b4 ^= 8'($urandom_range(1, 255));
		return {b0, b1, b2, b3, b4};
	endfunction

	// Fill frame_gaps with the 82 intervals of a well-formed frame carrying data.
	task automatic queue_frame_gaps(logic [BITS_W-1:0] data);
		frame_gaps.delete();
		frame_gaps.push_back(pick_in_window(PRE_MIN, PRE_MAX));
		frame_gaps.push_back(pick_in_window(PRE_MIN, PRE_MAX));
		for (int i = BITS_W - 1; i >= 0; i--) begin
			frame_gaps.push_back(pick_in_window(LOW_MIN, LOW_MAX));
			if (data[i])
				frame_gaps.push_back(pick_in_window(ONE_MIN, ONE_MAX));
			else
				frame_gaps.push_back(pick_in_window(ZERO_MIN, ZERO_MAX));
		end
	endtask

	// Offer one item after a random gap and hold it until the transfer.
	// Valid stays high between back-to-back items, so it is never dropped and
	// raised in the same step.
	task automatic send_item(opcode_t op, logic [TIMER_W-1:0] stamp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.opcode      <= op;
		item_bus.timer_value <= stamp;
		@(posedge clk);
		while (item_bus.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
		if (op == OP_END)
			ends_sent++;
	endtask

	// Walk the queued intervals as absolute timer readings.
	task automatic send_frame_edges();
		logic [TIMER_W-1:0] stamp;
		stamp = '0;
		foreach (frame_gaps[i]) begin
			stamp += frame_gaps[i];
			send_item(OP_EDGE, stamp);
		end
	endtask

	// Drop valid, wait for every expected result, then let the pipeline drain.
	task automatic settle();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_kind(logic value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cfg_writes++;
	endtask

	// One stretch of traffic: mostly well-formed frames with random content,
	// the rest broken, cut short, overlong or plain noise.
	task automatic run_episode();
		int kind;
		int n;
		int idx;
		kind = $urandom_range(0, 99);
		idle_off = ($urandom_range(0, 3) == 0);
		if (kind >= 90) begin
			n = $urandom_range(1, 20);
			repeat (n) send_item(opcode_t'($urandom_range(0, 3)), TIMER_W'($urandom));
			return;
		end
		queue_frame_gaps(random_frame_bits($urandom_range(0, 4) == 0));
		if (kind >= 55 && kind < 70) begin
			// Break one interval: preamble, low phase or high phase by position.
			idx = $urandom_range(0, FRAME_INTERVALS - 1);
			if (idx < 2)
				frame_gaps[idx] = pick_off_window(PRE_MIN, PRE_MAX);
			else if (idx % 2 == 0)
				frame_gaps[idx] = pick_off_window(LOW_MIN, LOW_MAX);
			else
				frame_gaps[idx] = pick_bad_high();
		end else if (kind >= 70 && kind < 80) begin
			n = $urandom_range(0, FRAME_INTERVALS - 1);
			while (frame_gaps.size() > n)
				void'(frame_gaps.pop_back());
		end else if (kind >= 80) begin
			// Extra edges past the last interval must be ignored.
			n = $urandom_range(1, 5);
			repeat (n) frame_gaps.push_back(TIMER_W'($urandom));
		end
		// Now and then skip the start so the frame runs on from old state.
		if ($urandom_range(0, 9) != 0)
			send_item(OP_START, TIMER_W'($urandom));
		send_frame_edges();
		n = $urandom_range(1, 2);
		repeat (n) send_item(OP_END, TIMER_W'($urandom));
	endtask

	task automatic run_phase(int n_items, int n_ends);
		int item_goal;
		int end_goal;
		item_goal = items_sent + n_items;
		end_goal  = ends_sent + n_ends;
		while (items_sent < item_goal || ends_sent < end_goal)
			run_episode();
	endtask

	// Ask the receiver for its long hold-off and wait until it has begun, then
	// keep offering a frame and a string of end items back to back so the
	// result side fills and the input stalls.
	task automatic pressure_burst();
		stall_request = 1'b1;
		idle_off = 1'b1;
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (!stall_active)
			@(posedge clk);
		queue_frame_gaps(random_frame_bits(1'b0));
		send_item(OP_START, '0);
		send_frame_edges();
		repeat (20) send_item(OP_END, TIMER_W'($urandom));
	endtask

	// Result side: random runs of ready, a few long stalls, stretches with none,
	// and the one long hold-off when the sender asks for it.
	initial begin : result_sink
		int r;
		int run;
		logic level;
		result_bus.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (stall_request && !stall_done) begin
				result_bus.ready <= 1'b0;
				stall_active = 1'b1;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					level = 1'b1;
					run = $urandom_range(1, 20);
				end else if (r < 65) begin
					level = 1'b1;
					run = $urandom_range(50, 150);
				end else if (r < 92) begin
					level = 1'b0;
					run = $urandom_range(1, 3);
				end else begin
					level = 1'b0;
					run = $urandom_range(10, 60);
				end
				result_bus.ready <= level;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		arst_n               <= 1'b0;
		cfg_wr_en            <= 1'b0;
		cfg_wr_data          <= 1'b0;
		end_of_run           <= 1'b0;
		item_bus.valid       <= 1'b0;
		item_bus.opcode      <= OP_NOP;
		item_bus.timer_value <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_kind(1'b1);

		// Directed: an end with nothing captured, an ignored opcode, each
		// interval error at its limit, a repeated end, and a preamble gap that
		// wraps the timer.
		send_item(OP_END, 16'hFFFF);
		send_item(OP_NOP, 16'hFFFF);
		send_item(OP_START, 16'h0000);
		send_item(OP_EDGE, 16'd59);
		send_item(OP_END, 16'h0000);
		send_item(OP_END, 16'h5A5A);
		send_item(OP_START, 16'hFFFF);
		send_item(OP_EDGE, 16'd60);
		send_item(OP_EDGE, 16'd160);
		send_item(OP_EDGE, 16'd194);
		send_item(OP_END, 16'h0000);
		send_item(OP_START, 16'h0000);
		send_item(OP_EDGE, 16'd100);
		send_item(OP_EDGE, 16'd160);
		send_item(OP_EDGE, 16'd195);
		send_item(OP_EDGE, 16'd241);
		send_item(OP_END, 16'h0000);
		send_item(OP_START, 16'h0000);
		send_item(OP_EDGE, 16'd101);
		send_item(OP_EDGE, 16'd0);
		send_item(OP_END, 16'h0000);
		settle();

		// Unsupported sensor kind: every frame must fail.
		write_kind(1'b0);
		run_phase(120, 2);
		settle();

		write_kind(1'b1);
		run_phase(400, 8);
		pressure_burst();
		run_phase(400, 8);
		settle();

		write_kind(1'b0);
		run_phase(60, 1);
		settle();
		write_kind(1'b1);
		run_phase(60, 1);
		settle();

		// Flag leftovers and let the checker fold them in before the summary.
		end_of_run <= 1'b1;
		repeat (3) @(posedge clk);

		$display("run covered %0d transfers in, %0d frame ends, %0d config writes",
			items_sent, ends_sent, cfg_writes);
		$display("checked %0d results, %0d of them good frames", checked, good_frames);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
